FILE: hdl/mpva_pkg.sv
package mpva_pkg;

    localparam int CHIPS = 2;
    localparam int MAX_VOICES_PER_CHANNEL = 3;

    // three tone channels per chip, never more than six voices
    localparam int NVOICES = ((CHIPS * 3) < 6) ? (CHIPS * 3) : 6;
    localparam int MIX_N = (NVOICES + 2) / 3;
    localparam int VIDX_W = (NVOICES > 1) ? $clog2(NVOICES) : 1;
    localparam int KCNT_W = $clog2(MAX_VOICES_PER_CHANNEL + 1);
    localparam int STEP_W = 3;
    localparam int MAP_W = 30;

    localparam logic [7:0] IDLE_NOTE = 8'd128;
    localparam logic [7:0] MIXER_RESET = 8'd255;
    localparam logic [6:0] NOTE_MIN = 7'd35;
    localparam logic [6:0] NOTE_LOW_DRUM = 7'd37;
    localparam logic [6:0] NOTE_DRUM_41 = 7'd41;
    localparam logic [6:0] NOTE_MID_DRUM = 7'd42;
    localparam logic [6:0] NOTE_DRUM_47 = 7'd47;
    localparam logic [6:0] NOTE_DRUM_48 = 7'd48;
    localparam logic [3:0] PERC_CHANNEL = 4'd9;
    localparam logic [6:0] CC_VOLUME = 7'd7;
    localparam logic [6:0] CC_ALL_OFF = 7'd120;

    // sound chip register numbers
    localparam logic [3:0] REG_NOISE = 4'd6;
    localparam logic [3:0] REG_MIXER = 4'd7;
    localparam logic [3:0] REG_ENV_FINE = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam logic [7:0] NOISE_LOW = 8'h1F;
    localparam logic [7:0] NOISE_MID = 8'h0F;
    localparam logic [7:0] NOISE_HIGH = 8'h00;
    localparam logic [7:0] ENV_COARSE_LOW = 8'h04;
    localparam logic [7:0] ENV_COARSE_HIGH = 8'h1C;
    localparam logic [7:0] VOL_ENVELOPE = 8'h10;

    typedef enum logic [1:0] {
        CMD_NOTE_ON,
        CMD_NOTE_OFF,
        CMD_CONTROL,
        CMD_IGNORE
    } cmd_t;

    typedef enum logic [1:0] {
        LK_LITERAL,
        LK_PERIOD_HI,
        LK_PERIOD_LO
    } lk_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_VOLUME,
        OP_ALL_OFF,
        OP_TONE,
        OP_PERC
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic       start;
        logic [3:0] ch;
        logic [7:0] target;
    } scan_req_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [VIDX_W-1:0]  hit_voice;
        logic [NVOICES-1:0] slot_mask;
    } scan_res_t;

    function automatic logic voice_chip(input logic [VIDX_W-1:0] v);
        return (v >= VIDX_W'(3));
    endfunction

    function automatic logic [1:0] voice_chl(input logic [VIDX_W-1:0] v);
        if (v >= VIDX_W'(3))
        begin
            return 2'(v - VIDX_W'(3));
        end
        else
        begin
            return 2'(v);
        end
    endfunction

endpackage

FILE: hdl/midi_to_psg_voice_allocator_unit.sv
// Channel  Ports                         Direction  Carries
// s_axis   tvalid tready tdata tuser     in         one MIDI message
// m_axis   tvalid tready tdata tuser     out        one chip register write
//          tlast
// cfg      valid ready data              in         voice_channel_map
//
// Note on, note off and controller 7 first scan the six voices, one per cycle
// through a single note compare, then settle state in the commit state. All-off
// skips the scan. Writes leave one per cycle from the output register; a stalled
// m_axis holds the sequencer. s_axis is ready only while idle.
// Reset: map cleared, mixers 0xFF, all voices idle.
module midi_to_psg_voice_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // midi_channel, data1, data2
    input  logic [1:0]                    s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // chip, reg_addr, reg_value
    output logic [1:0]                    m_axis_tuser,  // lookup_kind
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mpva_pkg::MAP_W-1:0]    cfg_data
);

    mpva_pkg::st_t                       state_reg, state_next;
    mpva_pkg::op_t                       op_reg;
    logic [3:0]                          ch_reg;
    logic [6:0]                          note_reg;
    logic [6:0]                          velo_reg;
    logic [mpva_pkg::VIDX_W-1:0]         voice_reg;
    logic [mpva_pkg::NVOICES-1:0]        rem_mask_reg;
    logic [STEP_W_L-1:0]                 step_reg;
    logic [mpva_pkg::MAP_W-1:0]          map_reg;
    logic [7:0]                          mixer_reg [mpva_pkg::MIX_N];
    logic [7:0]                          mixer_next [mpva_pkg::MIX_N];
    logic [mpva_pkg::NVOICES-1:0][7:0]   voice_note_reg, voice_note_next;

    logic                                m_valid_reg;
    logic                                m_chip_reg;
    logic [3:0]                          m_addr_reg;
    logic [7:0]                          m_value_reg;
    logic [1:0]                          m_kind_reg;
    logic                                m_last_reg;

    localparam int STEP_W_L = mpva_pkg::STEP_W;

    mpva_pkg::cmd_t                      in_cmd;
    logic [3:0]                          in_ch;
    logic [6:0]                          in_d1;
    logic [6:0]                          in_d2;
    mpva_pkg::op_t                       dec_op;
    logic                                in_fire;

    mpva_pkg::scan_req_t                 scan_req;
    mpva_pkg::scan_res_t                 scan_res;

    logic                                emit_en;
    logic                                emit_fire;
    logic                                emit_last;
    logic                                commit_go;
    logic [mpva_pkg::VIDX_W-1:0]         cur_voice;
    logic [mpva_pkg::VIDX_W-1:0]         vol_voice;
    logic [mpva_pkg::NVOICES-1:0]        vol_bit;
    logic                                cur_chip;
    logic [1:0]                          cur_chl;
    logic [7:0]                          cur_mix;
    logic [7:0]                          tone_bit;
    logic [7:0]                          noise_bit;
    logic [3:0]                          emit_addr;
    logic [7:0]                          emit_value;
    mpva_pkg::lk_t                       emit_kind;
    logic                                drum_low;
    logic                                drum_mid;
    logic                                hv_chip;
    logic [1:0]                          hv_chl;
    logic [7:0]                          hv_mix;

    // ---------------- input decode ----------------
    assign in_cmd = mpva_pkg::cmd_t'(s_axis_tuser);
    assign in_ch = s_axis_tdata[3:0];
    assign in_d1 = s_axis_tdata[10:4];
    assign in_d2 = s_axis_tdata[17:11];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        case (in_cmd)
            mpva_pkg::CMD_NOTE_ON:
            begin
                if (in_d2 == 7'd0)
                    dec_op = mpva_pkg::OP_NOTE_OFF;
                else if (in_d1 < mpva_pkg::NOTE_MIN)
                    dec_op = mpva_pkg::OP_NONE;
                else
                    dec_op = mpva_pkg::OP_NOTE_ON;
            end
            mpva_pkg::CMD_NOTE_OFF:
                dec_op = mpva_pkg::OP_NOTE_OFF;
            mpva_pkg::CMD_CONTROL:
            begin
                if (in_d1 == mpva_pkg::CC_VOLUME)
                    dec_op = mpva_pkg::OP_VOLUME;
                else if (in_d1 >= mpva_pkg::CC_ALL_OFF)
                    dec_op = mpva_pkg::OP_ALL_OFF;
                else
                    dec_op = mpva_pkg::OP_NONE;
            end
            default:
                dec_op = mpva_pkg::OP_NONE;
        endcase
    end

    // ---------------- slot scan ----------------
    always_comb
    begin
        scan_req.start = in_fire && (dec_op == mpva_pkg::OP_NOTE_ON ||
                                     dec_op == mpva_pkg::OP_NOTE_OFF ||
                                     dec_op == mpva_pkg::OP_VOLUME);
        scan_req.ch = in_ch;
        scan_req.target = (dec_op == mpva_pkg::OP_NOTE_ON) ? mpva_pkg::IDLE_NOTE
                                                           : {1'b0, in_d1};
    end

    mpva_slot_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (scan_req),
        .voice_map  (map_reg),
        .voice_note (voice_note_reg),
        .res        (scan_res)
    );

    // commit proceeds only when the scan found something to act on
    always_comb
    begin
        case (op_reg)
            mpva_pkg::OP_NOTE_ON,
            mpva_pkg::OP_NOTE_OFF:
                commit_go = scan_res.hit;
            mpva_pkg::OP_VOLUME:
                commit_go = (scan_res.slot_mask != '0);
            default:
                commit_go = 1'b0;
        endcase
    end

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpva_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (dec_op == mpva_pkg::OP_ALL_OFF)
                        state_next = mpva_pkg::ST_EMIT;
                    else if (dec_op != mpva_pkg::OP_NONE)
                        state_next = mpva_pkg::ST_SCAN;
                end
            end
            mpva_pkg::ST_SCAN:
            begin
                if (scan_res.done)
                    state_next = mpva_pkg::ST_COMMIT;
            end
            mpva_pkg::ST_COMMIT:
            begin
                state_next = commit_go ? mpva_pkg::ST_EMIT : mpva_pkg::ST_IDLE;
            end
            mpva_pkg::ST_EMIT:
            begin
                if (emit_fire && emit_last)
                    state_next = mpva_pkg::ST_IDLE;
            end
            default:
                state_next = mpva_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        emit_en = 1'b0;
        case (state_reg)
            mpva_pkg::ST_IDLE:
                s_axis_tready = 1'b1;
            mpva_pkg::ST_EMIT:
                emit_en = 1'b1;
            default:
            begin
                s_axis_tready = 1'b0;
                emit_en = 1'b0;
            end
        endcase
    end

    assign emit_fire = emit_en && (!m_valid_reg || m_axis_tready);

    // ---------------- write generation ----------------
    always_comb
    begin
        vol_voice = '0;
        for (int i = mpva_pkg::NVOICES - 1; i >= 0; i--)
        begin
            if (rem_mask_reg[i])
                vol_voice = mpva_pkg::VIDX_W'(i);
        end
    end

    assign vol_bit = mpva_pkg::NVOICES'(1) << vol_voice;

    always_comb
    begin
        case (op_reg)
            mpva_pkg::OP_ALL_OFF:
                cur_voice = step_reg[mpva_pkg::VIDX_W-1:0];
            mpva_pkg::OP_VOLUME:
                cur_voice = vol_voice;
            default:
                cur_voice = voice_reg;
        endcase
    end

    assign cur_chip = mpva_pkg::voice_chip(cur_voice);
    assign cur_chl = mpva_pkg::voice_chl(cur_voice);
    assign cur_mix = mixer_reg[cur_chip];
    assign tone_bit = 8'd1 << cur_chl;
    assign noise_bit = 8'd8 << cur_chl;

    assign drum_low = (note_reg < mpva_pkg::NOTE_LOW_DRUM) ||
                      (note_reg == mpva_pkg::NOTE_DRUM_41);
    assign drum_mid = (note_reg < mpva_pkg::NOTE_MID_DRUM) ||
                      (note_reg == mpva_pkg::NOTE_DRUM_47) ||
                      (note_reg == mpva_pkg::NOTE_DRUM_48);

    always_comb
    begin
        emit_addr = mpva_pkg::REG_MIXER;
        emit_value = cur_mix;
        emit_kind = mpva_pkg::LK_LITERAL;
        emit_last = 1'b1;
        case (op_reg)
            mpva_pkg::OP_TONE:
            begin
                emit_last = (step_reg == STEP_W_L'(3));
                case (step_reg)
                    STEP_W_L'(0):
                    begin
                        emit_addr = {cur_chl, 1'b1};
                        emit_value = {1'b0, note_reg};
                        emit_kind = mpva_pkg::LK_PERIOD_HI;
                    end
                    STEP_W_L'(1):
                    begin
                        emit_addr = {cur_chl, 1'b0};
                        emit_value = {1'b0, note_reg};
                        emit_kind = mpva_pkg::LK_PERIOD_LO;
                    end
                    STEP_W_L'(2):
                    begin
                        emit_addr = mpva_pkg::REG_MIXER;
                        emit_value = cur_mix;
                    end
                    default:
                    begin
                        emit_addr = {2'b10, cur_chl};
                        emit_value = {4'd0, velo_reg[6:3]};
                    end
                endcase
            end
            mpva_pkg::OP_PERC:
            begin
                emit_last = (step_reg == STEP_W_L'(5));
                case (step_reg)
                    STEP_W_L'(0):
                    begin
                        emit_addr = mpva_pkg::REG_NOISE;
                        if (drum_low)
                            emit_value = mpva_pkg::NOISE_LOW;
                        else if (drum_mid)
                            emit_value = mpva_pkg::NOISE_MID;
                        else
                            emit_value = mpva_pkg::NOISE_HIGH;
                    end
                    STEP_W_L'(1):
                    begin
                        emit_addr = mpva_pkg::REG_ENV_COARSE;
                        emit_value = (drum_low || drum_mid) ? mpva_pkg::ENV_COARSE_LOW
                                                            : mpva_pkg::ENV_COARSE_HIGH;
                    end
                    STEP_W_L'(2):
                    begin
                        emit_addr = mpva_pkg::REG_ENV_FINE;
                        emit_value = 8'd0;
                    end
                    STEP_W_L'(3):
                    begin
                        emit_addr = {2'b10, cur_chl};
                        emit_value = mpva_pkg::VOL_ENVELOPE;
                    end
                    STEP_W_L'(4):
                    begin
                        emit_addr = mpva_pkg::REG_ENV_SHAPE;
                        emit_value = 8'd0;
                    end
                    default:
                    begin
                        emit_addr = mpva_pkg::REG_MIXER;
                        emit_value = cur_mix;
                    end
                endcase
            end
            mpva_pkg::OP_NOTE_OFF:
            begin
                emit_addr = mpva_pkg::REG_MIXER;
                emit_value = cur_mix;
            end
            mpva_pkg::OP_ALL_OFF:
            begin
                emit_last = (step_reg == STEP_W_L'(mpva_pkg::NVOICES - 1));
                emit_addr = mpva_pkg::REG_MIXER;
                emit_value = cur_mix | tone_bit | noise_bit;
            end
            mpva_pkg::OP_VOLUME:
            begin
                emit_last = ((rem_mask_reg & ~vol_bit) == '0);
                emit_addr = {2'b10, cur_chl};
                emit_value = {4'd0, velo_reg[6:3]};
            end
            default:
            begin
                emit_addr = mpva_pkg::REG_MIXER;
                emit_value = cur_mix;
            end
        endcase
    end

    // ---------------- voice and mixer state ----------------
    assign hv_chip = mpva_pkg::voice_chip(scan_res.hit_voice);
    assign hv_chl = mpva_pkg::voice_chl(scan_res.hit_voice);
    assign hv_mix = mixer_reg[hv_chip];

    always_comb
    begin
        mixer_next = mixer_reg;
        voice_note_next = voice_note_reg;
        if (state_reg == mpva_pkg::ST_COMMIT && scan_res.hit)
        begin
            if (op_reg == mpva_pkg::OP_NOTE_ON)
            begin
                voice_note_next[scan_res.hit_voice] = {1'b0, note_reg};
                if (ch_reg != mpva_pkg::PERC_CHANNEL)
                    mixer_next[hv_chip] = hv_mix & ~(8'd1 << hv_chl);
                else if (drum_low)
                    // low drums keep the noise enable as it was
                    mixer_next[hv_chip] = hv_mix | (8'd1 << hv_chl);
                else
                    mixer_next[hv_chip] = (hv_mix & ~(8'd8 << hv_chl)) | (8'd1 << hv_chl);
            end
            else if (op_reg == mpva_pkg::OP_NOTE_OFF)
            begin
                voice_note_next[scan_res.hit_voice] = mpva_pkg::IDLE_NOTE;
                mixer_next[hv_chip] = hv_mix | (8'd1 << hv_chl) | (8'd8 << hv_chl);
            end
        end
        if (emit_fire && op_reg == mpva_pkg::OP_ALL_OFF)
        begin
            voice_note_next[cur_voice] = mpva_pkg::IDLE_NOTE;
            mixer_next[cur_chip] = cur_mix | tone_bit | noise_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpva_pkg::ST_IDLE;
            map_reg <= '0;
            for (int i = 0; i < mpva_pkg::MIX_N; i++)
                mixer_reg[i] <= mpva_pkg::MIXER_RESET;
            for (int i = 0; i < mpva_pkg::NVOICES; i++)
                voice_note_reg[i] <= mpva_pkg::IDLE_NOTE;
            m_valid_reg <= 1'b0;
            op_reg <= mpva_pkg::OP_NONE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                map_reg <= cfg_data;
            mixer_reg <= mixer_next;
            voice_note_reg <= voice_note_next;

            if (emit_fire)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;

            if (in_fire)
            begin
                op_reg <= dec_op;
                step_reg <= '0;
            end
            else if (state_reg == mpva_pkg::ST_COMMIT && op_reg == mpva_pkg::OP_NOTE_ON)
            begin
                op_reg <= (ch_reg == mpva_pkg::PERC_CHANNEL) ? mpva_pkg::OP_PERC
                                                             : mpva_pkg::OP_TONE;
            end
            else if (emit_fire)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg <= in_ch;
            note_reg <= in_d1;
            velo_reg <= in_d2;
        end
        if (state_reg == mpva_pkg::ST_COMMIT)
        begin
            voice_reg <= scan_res.hit_voice;
            rem_mask_reg <= scan_res.slot_mask;
        end
        else if (emit_fire && op_reg == mpva_pkg::OP_VOLUME)
        begin
            rem_mask_reg <= rem_mask_reg & ~vol_bit;
        end
        if (emit_fire)
        begin
            m_chip_reg <= cur_chip;
            m_addr_reg <= emit_addr;
            m_value_reg <= emit_value;
            m_kind_reg <= emit_kind;
            m_last_reg <= emit_last;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = {3'b000, m_value_reg, m_addr_reg, m_chip_reg};
    assign m_axis_tuser = m_kind_reg;
    assign m_axis_tlast = m_last_reg;

    // ---------------- assertions ----------------
    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> state_reg == mpva_pkg::ST_SCAN)
        else $error("scan finished outside of scan state");

    a_alloc_idle_voice: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpva_pkg::ST_COMMIT && op_reg == mpva_pkg::OP_NOTE_ON && scan_res.hit)
        |-> voice_note_reg[scan_res.hit_voice] == mpva_pkg::IDLE_NOTE)
        else $error("note on took a busy voice");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_last) |=> state_reg == mpva_pkg::ST_IDLE)
        else $error("sequencer kept running after final write");

    a_alloff_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpva_pkg::ST_EMIT && op_reg == mpva_pkg::OP_ALL_OFF)
        |-> step_reg < STEP_W_L'(mpva_pkg::NVOICES))
        else $error("all-off step past last voice");

endmodule

FILE: hdl/mpva_slot_scan.sv
module mpva_slot_scan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpva_pkg::scan_req_t                  req,
    input  logic [mpva_pkg::MAP_W-1:0]           voice_map,
    input  logic [mpva_pkg::NVOICES-1:0][7:0]    voice_note,
    output mpva_pkg::scan_res_t                  res
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [mpva_pkg::VIDX_W-1:0]         v_reg, v_next;
    logic [mpva_pkg::KCNT_W-1:0]         k_reg, k_next;
    logic                                hit_reg, hit_next;
    logic [mpva_pkg::VIDX_W-1:0]         hit_voice_reg, hit_voice_next;
    logic [mpva_pkg::NVOICES-1:0]        mask_reg, mask_next;
    logic [3:0]                          ch_reg, ch_next;
    logic [7:0]                          target_reg, target_next;

    logic [mpva_pkg::NVOICES-1:0][4:0]   map_grp;
    logic                                is_slot;
    logic                                note_eq;

    assign map_grp = voice_map[mpva_pkg::NVOICES*5-1:0];

    // one voice per cycle through a single compare
    assign is_slot = map_grp[v_reg][4] && (map_grp[v_reg][3:0] == ch_reg)
                     && (k_reg < KCNT_MAX);
    assign note_eq = (voice_note[v_reg] == target_reg);

    localparam logic [mpva_pkg::KCNT_W-1:0] KCNT_MAX =
        mpva_pkg::KCNT_W'(mpva_pkg::MAX_VOICES_PER_CHANNEL);
    localparam logic [mpva_pkg::VIDX_W-1:0] V_LAST =
        mpva_pkg::VIDX_W'(mpva_pkg::NVOICES - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next = v_reg;
        k_next = k_reg;
        hit_next = hit_reg;
        hit_voice_next = hit_voice_reg;
        mask_next = mask_reg;
        ch_next = ch_reg;
        target_next = target_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            v_next = '0;
            k_next = '0;
            hit_next = 1'b0;
            hit_voice_next = '0;
            mask_next = '0;
            ch_next = req.ch;
            target_next = req.target;
        end
        else if (busy_reg)
        begin
            if (is_slot)
            begin
                mask_next[v_reg] = 1'b1;
                k_next = k_reg + 1'b1;
                if (note_eq && !hit_reg)
                begin
                    hit_next = 1'b1;
                    hit_voice_next = v_reg;
                end
            end
            if (v_reg == V_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                v_next = v_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            v_reg <= '0;
            k_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            v_reg <= v_next;
            k_reg <= k_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_voice_reg <= hit_voice_next;
        mask_reg <= mask_next;
        ch_reg <= ch_next;
        target_reg <= target_next;
    end

    assign res.done = done_reg;
    assign res.hit = hit_reg;
    assign res.hit_voice = hit_voice_reg;
    assign res.slot_mask = mask_reg;

endmodule

FILE: bench/midi_to_psg_voice_allocator_unit_test.sv
module midi_to_psg_voice_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpva_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 6;

    // tone registers of channel A/B/C and the volume register of A, used in the directed rows
    localparam logic [3:0] REG_PERIOD_HI_A = 4'd1;
    localparam logic [3:0] REG_PERIOD_HI_B = 4'd3;
    localparam logic [3:0] REG_PERIOD_HI_C = 4'd5;
    localparam logic [3:0] REG_VOLUME_A = 4'd8;

    typedef struct packed {
        logic       chip;
        logic [3:0] reg_addr;
        logic [7:0] reg_value;
        lk_t        lookup_kind;
        logic       last;
    } psg_write_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        int         n;       // typed write count, -1 when left to the predictor
        logic       first;   // first write typed in below
        logic       chip;
        logic [3:0] reg_addr;
        logic [7:0] reg_value;
        lk_t        lookup_kind;
    } msg_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata = '0;   // midi_channel, data1, data2
    logic [1:0]       s_axis_tuser = '0;   // cmd
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [15:0]      m_axis_tdata;        // chip, reg_addr, reg_value
    logic [1:0]       m_axis_tuser;        // lookup_kind
    logic             m_axis_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [MAP_W-1:0] cfg_data = '0;

    midi_to_psg_voice_allocator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [MAP_W-1:0] voice_map = '0;
    logic [7:0]       mixer_state [CHIPS];
    logic [7:0]       voice_note [6];

    psg_write_t msg_writes[$];
    psg_write_t expected_writes[$];

    int error_count = 0;
    int cycle_count = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    bit quiet = 1'b0;

    msg_row_t msg_rows [0:25] = '{
        '{CMD_IGNORE,   4'd0, 7'd60,  7'd100, 0, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_CONTROL,  4'd0, 7'd119, 7'd64,  0, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  4'd0, 7'd34,  7'd100, 0, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  4'd0, 7'd35,  7'd127, 4, 1'b1, 1'b0, REG_PERIOD_HI_A, 8'd35,
          LK_PERIOD_HI},
        '{CMD_NOTE_ON,  4'd0, 7'd127, 7'd8,   4, 1'b1, 1'b0, REG_PERIOD_HI_B, 8'd127,
          LK_PERIOD_HI},
        '{CMD_NOTE_ON,  4'd0, 7'd60,  7'd127, 4, 1'b1, 1'b0, REG_PERIOD_HI_C, 8'd60,
          LK_PERIOD_HI},
        // all three slots busy; the fourth bound voice does not count
        '{CMD_NOTE_ON,  4'd0, 7'd70,  7'd100, 0, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        // velocity zero releases the voice holding 127
        '{CMD_NOTE_ON,  4'd0, 7'd127, 7'd0,   1, 1'b1, 1'b0, REG_MIXER, 8'hFA, LK_LITERAL},
        '{CMD_NOTE_OFF, 4'd0, 7'd99,  7'd0,   0, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_CONTROL,  4'd0, CC_VOLUME, 7'd127, 3, 1'b1, 1'b0, REG_VOLUME_A, 8'd15,
          LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd35, 7'd1, 6, 1'b1, 1'b1, REG_NOISE, NOISE_LOW,
          LK_LITERAL},
        '{CMD_NOTE_OFF, PERC_CHANNEL, 7'd35, 7'd0, 1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd41, 7'd64, 6, 1'b1, 1'b1, REG_NOISE, NOISE_LOW,
          LK_LITERAL},
        '{CMD_NOTE_OFF, PERC_CHANNEL, 7'd41, 7'd127, -1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd40, 7'd64, 6, 1'b1, 1'b1, REG_NOISE, NOISE_MID,
          LK_LITERAL},
        '{CMD_NOTE_OFF, PERC_CHANNEL, 7'd40, 7'd0, -1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd47, 7'd64, -1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_OFF, PERC_CHANNEL, 7'd47, 7'd0, -1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd48, 7'd127, -1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_OFF, PERC_CHANNEL, 7'd48, 7'd0, -1, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd100, 7'd127, 6, 1'b1, 1'b1, REG_NOISE, NOISE_HIGH,
          LK_LITERAL},
        '{CMD_NOTE_ON,  4'd15, 7'd127, 7'd127, 4, 1'b1, 1'b1, REG_PERIOD_HI_B, 8'd127,
          LK_PERIOD_HI},
        '{CMD_CONTROL,  4'd0, CC_ALL_OFF, 7'd0, 6, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL},
        '{CMD_CONTROL,  4'd15, 7'd127, 7'd127, 6, 1'b1, 1'b0, REG_MIXER, 8'hFF, LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd37, 7'd64, 6, 1'b1, 1'b1, REG_NOISE, NOISE_MID,
          LK_LITERAL},
        '{CMD_NOTE_ON,  PERC_CHANNEL, 7'd36, 7'd0, 0, 1'b0, 1'b0, 4'd0, 8'd0, LK_LITERAL}
    };

    initial
    begin
        for (int i = 0; i < CHIPS; i++)
        begin
            mixer_state[i] = MIXER_RESET;
        end
        for (int i = 0; i < 6; i++)
        begin
            voice_note[i] = IDLE_NOTE;
        end
    end

    function automatic int bound_slots(input logic [3:0] ch, output int slot [6]);
        int k;
        logic [4:0] grp;
        k = 0;
        for (int v = 0; v < NVOICES; v++)
        begin
            grp = voice_map[5*v +: 5];
            if (k < MAX_VOICES_PER_CHANNEL && grp[4] && grp[3:0] == ch)
            begin
                slot[k] = v;
                k++;
            end
        end
        return k;
    endfunction

    function automatic void add_write(input int v, input logic [3:0] reg_addr,
                                      input logic [7:0] reg_value, input lk_t kind);
        psg_write_t w;
        w.chip = 1'(v / 3);
        w.reg_addr = reg_addr;
        w.reg_value = reg_value;
        w.lookup_kind = kind;
        w.last = 1'b0;
        msg_writes.push_back(w);
    endfunction

    function automatic void release_voice(input int v);
        int c;
        int chl;
        c = v / 3;
        chl = v % 3;
        mixer_state[c] = mixer_state[c] | 8'(1 << chl) | 8'(1 << (chl + 3));
        add_write(v, REG_MIXER, mixer_state[c], LK_LITERAL);
        voice_note[v] = IDLE_NOTE;
    endfunction

    function automatic void note_release(input logic [3:0] ch, input logic [6:0] note);
        int slot [6];
        int k;
        k = bound_slots(ch, slot);
        for (int i = 0; i < k; i++)
        begin
            if (voice_note[slot[i]] == {1'b0, note})
            begin
                release_voice(slot[i]);
                return;
            end
        end
    endfunction

    function automatic void note_start(input logic [3:0] ch, input logic [6:0] note,
                                       input logic [6:0] velo);
        int slot [6];
        int k;
        int i;
        int v;
        int c;
        int chl;
        logic [7:0] mask;
        if (velo == 7'd0)
        begin
            note_release(ch, note);
            return;
        end
        k = bound_slots(ch, slot);
        for (i = 0; i < k; i++)
        begin
            if (voice_note[slot[i]] == IDLE_NOTE)
            begin
                break;
            end
        end
        if (i >= k || note < NOTE_MIN)
        begin
            return;
        end
        v = slot[i];
        c = v / 3;
        chl = v % 3;
        voice_note[v] = {1'b0, note};
        if (ch != PERC_CHANNEL)
        begin
            mixer_state[c] = mixer_state[c] & ~8'(1 << chl);
            add_write(v, 4'(chl * 2 + 1), {1'b0, note}, LK_PERIOD_HI);
            add_write(v, 4'(chl * 2), {1'b0, note}, LK_PERIOD_LO);
            add_write(v, REG_MIXER, mixer_state[c], LK_LITERAL);
            add_write(v, 4'(chl + 8), 8'(velo >> 3), LK_LITERAL);
            return;
        end
        mask = mixer_state[c];
        // low drums leave the noise enable alone
        if (note < NOTE_LOW_DRUM || note == NOTE_DRUM_41)
        begin
            mixer_state[c] = mask | 8'(1 << chl);
            add_write(v, REG_NOISE, NOISE_LOW, LK_LITERAL);
            add_write(v, REG_ENV_COARSE, ENV_COARSE_LOW, LK_LITERAL);
        end
        else if (note < NOTE_MID_DRUM || note == NOTE_DRUM_47 || note == NOTE_DRUM_48)
        begin
            mixer_state[c] = (mask & ~8'(1 << (chl + 3))) | 8'(1 << chl);
            add_write(v, REG_NOISE, NOISE_MID, LK_LITERAL);
            add_write(v, REG_ENV_COARSE, ENV_COARSE_LOW, LK_LITERAL);
        end
        else
        begin
            mixer_state[c] = (mask & ~8'(1 << (chl + 3))) | 8'(1 << chl);
            add_write(v, REG_NOISE, NOISE_HIGH, LK_LITERAL);
            add_write(v, REG_ENV_COARSE, ENV_COARSE_HIGH, LK_LITERAL);
        end
        add_write(v, REG_ENV_FINE, 8'd0, LK_LITERAL);
        add_write(v, 4'(chl + 8), VOL_ENVELOPE, LK_LITERAL);
        add_write(v, REG_ENV_SHAPE, 8'd0, LK_LITERAL);
        add_write(v, REG_MIXER, mixer_state[c], LK_LITERAL);
    endfunction

    function automatic void control_change(input logic [3:0] ch, input logic [6:0] num,
                                           input logic [6:0] val);
        int slot [6];
        int k;
        if (num == CC_VOLUME)
        begin
            k = bound_slots(ch, slot);
            for (int i = 0; i < k; i++)
            begin
                add_write(slot[i], 4'(slot[i] % 3 + 8), 8'(val >> 3), LK_LITERAL);
            end
        end
        else if (num >= CC_ALL_OFF)
        begin
            for (int v = 0; v < NVOICES; v++)
            begin
                release_voice(v);
            end
        end
    endfunction

    // updates the voice state and queues the register writes of one message
    function automatic int predict_writes(input cmd_t cmd, input logic [3:0] ch,
                                          input logic [6:0] d1, input logic [6:0] d2);
        msg_writes.delete();
        case (cmd)
            CMD_NOTE_ON:  note_start(ch, d1, d2);
            CMD_NOTE_OFF: note_release(ch, d1);
            CMD_CONTROL:  control_change(ch, d1, d2);
            default:      ;
        endcase
        if (msg_writes.size() > 0)
        begin
            msg_writes[msg_writes.size() - 1].last = 1'b1;
        end
        foreach (msg_writes[i])
        begin
            expected_writes.push_back(msg_writes[i]);
        end
        return msg_writes.size();
    endfunction

    function automatic logic [MAP_W-1:0] random_map();
        logic [MAP_W-1:0] m;
        logic [3:0] ch;
        m = '0;
        for (int v = 0; v < 6; v++)
        begin
            case ($urandom_range(2))
                0: ch = 4'd0;
                1: ch = PERC_CHANNEL;
                default: ch = 4'($urandom_range(15));
            endcase
            m[5*v +: 5] = {1'($urandom_range(3) != 0), ch};
        end
        return m;
    endfunction

    always @(posedge clk)
    begin : write_sink
        psg_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("unexpected write: chip %0d reg %0d value %0d", m_axis_tdata[0],
                       m_axis_tdata[4:1], m_axis_tdata[12:5]);
                error_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (m_axis_tdata[0] != want.chip)
                begin
                    $error("chip: expected %0d, got %0d", want.chip, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[4:1] != want.reg_addr)
                begin
                    $error("reg_addr: expected %0d, got %0d", want.reg_addr,
                           m_axis_tdata[4:1]);
                    error_count++;
                end
                if (m_axis_tdata[12:5] != want.reg_value)
                begin
                    $error("reg_value: expected %0d, got %0d", want.reg_value,
                           m_axis_tdata[12:5]);
                    error_count++;
                end
                if (m_axis_tuser != want.lookup_kind)
                begin
                    $error("lookup_kind: expected %0d, got %0d", want.lookup_kind,
                           m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast != want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
        m_axis_tready <= quiet || ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays high after an accept; a gap in the next call or a drain lowers it
    task automatic send_msg(input cmd_t cmd, input logic [3:0] ch, input logic [6:0] d1,
                            input logic [6:0] d2, output int n);
        while (!quiet && $urandom_range(99) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, d2, d1, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n = predict_writes(cmd, ch, d1, d2);
    endtask

    // wait for every queued write, then let a message with no writes finish
    task automatic drain_writes();
        s_axis_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_voice_map(input logic [MAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        voice_map = value;
    endtask

    task automatic random_msg();
        int r;
        int n;
        int v;
        int bound_ch[$];
        int sounding[$];
        cmd_t cmd;
        logic [3:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        for (int i = 0; i < NVOICES; i++)
        begin
            if (voice_map[5*i + 4])
            begin
                bound_ch.push_back(voice_map[5*i +: 4]);
            end
            if (voice_note[i] != IDLE_NOTE)
            begin
                sounding.push_back(i);
            end
        end
        if (bound_ch.size() > 0 && $urandom_range(99) < 85)
        begin
            ch = 4'(bound_ch[$urandom_range(bound_ch.size() - 1)]);
        end
        else
        begin
            ch = 4'($urandom_range(15));
        end
        d2 = 7'($urandom_range(127));
        r = $urandom_range(99);
        if (r < 45)
        begin
            cmd = CMD_NOTE_ON;
            d1 = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                          : 7'($urandom_range(127, NOTE_MIN));
            d2 = ($urandom_range(15) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
        end
        else if (r < 75)
        begin
            cmd = ($urandom_range(3) == 0) ? CMD_NOTE_ON : CMD_NOTE_OFF;
            if (cmd == CMD_NOTE_ON)
            begin
                d2 = 7'd0;
            end
            d1 = 7'($urandom_range(127));
            if (sounding.size() > 0 && $urandom_range(9) != 0)
            begin
                v = sounding[$urandom_range(sounding.size() - 1)];
                ch = voice_map[5*v +: 4];
                d1 = voice_note[v][6:0];
            end
        end
        else if (r < 85)
        begin
            cmd = CMD_CONTROL;
            d1 = CC_VOLUME;
        end
        else if (r < 90)
        begin
            cmd = CMD_CONTROL;
            d1 = 7'($urandom_range(127, CC_ALL_OFF));
        end
        else if (r < 95)
        begin
            cmd = CMD_CONTROL;
            d1 = 7'($urandom_range(127));
        end
        else
        begin
            cmd = CMD_IGNORE;
            d1 = 7'($urandom_range(127));
        end
        send_msg(cmd, ch, d1, d2, n);
    endtask

    initial
    begin : stimulus
        int n;
        int burst_left;
        logic [MAP_W-1:0] phase_map [PHASES];
        int phase_items [PHASES] = '{50, 45, 50, 15, 50, 40};
        int phase_gap [PHASES] = '{0, 76, 0, 34, 34, 0};
        int phase_stall [PHASES] = '{0, 0, 76, 34, 34, 0};
        burst_left = 0;
        phase_map[0] = random_map();
        phase_map[1] = '1;
        phase_map[2] = random_map();
        phase_map[3] = '0;
        phase_map[4] = random_map();
        phase_map[5] = random_map();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // voices 0-2 and 5 on channel 0, 3 on percussion, 4 on channel 15
        load_voice_map({5'h10, 5'h1F, {1'b1, PERC_CHANNEL}, 5'h10, 5'h10, 5'h10});
        foreach (msg_rows[i])
        begin
            send_msg(msg_rows[i].cmd, msg_rows[i].ch, msg_rows[i].d1, msg_rows[i].d2, n);
            if (msg_rows[i].n >= 0 && n != msg_rows[i].n)
            begin
                $error("write count: expected %0d, got %0d", msg_rows[i].n, n);
                error_count++;
            end
            if (msg_rows[i].first && n > 0)
            begin
                if (msg_writes[0].chip != msg_rows[i].chip)
                begin
                    $error("chip: expected %0d, got %0d", msg_rows[i].chip,
                           msg_writes[0].chip);
                    error_count++;
                end
                if (msg_writes[0].reg_addr != msg_rows[i].reg_addr)
                begin
                    $error("reg_addr: expected %0d, got %0d", msg_rows[i].reg_addr,
                           msg_writes[0].reg_addr);
                    error_count++;
                end
                if (msg_writes[0].reg_value != msg_rows[i].reg_value)
                begin
                    $error("reg_value: expected %0d, got %0d", msg_rows[i].reg_value,
                           msg_writes[0].reg_value);
                    error_count++;
                end
                if (msg_writes[0].lookup_kind != msg_rows[i].lookup_kind)
                begin
                    $error("lookup_kind: expected %0d, got %0d", msg_rows[i].lookup_kind,
                           msg_writes[0].lookup_kind);
                    error_count++;
                end
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_writes();
            load_voice_map(phase_map[p]);
            tx_gap_pct = phase_gap[p];
            rx_stall_pct = phase_stall[p];
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else if ($urandom_range(19) == 0)
                begin
                    burst_left = $urandom_range(12, 4);
                end
                quiet = (burst_left > 0);
                // hold off now and then until the block has emptied
                if (i % 25 == 24)
                begin
                    drain_writes();
                end
                random_msg();
            end
            quiet = 1'b0;
        end

        drain_writes();
        repeat (40) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
